FILE: rtl/idte_pkg.sv
`timescale 1ns / 1ps

package idte_pkg;

	localparam logic CMD_BINARY = 1'b0;
	localparam logic CMD_ASCII  = 1'b1;

	localparam logic [7:0] ASCII_ZERO     = 8'd48;
	localparam logic [7:0] YEAR_BASE_MOD  = 8'd108;  // 1900 mod 256
	localparam logic [7:0] MIN_YEAR       = 8'd70;   // 1970 - 1900
	localparam logic [7:0] YEAR_OFF       = 8'd60;   // 1960 - 1900
	localparam logic [11:0] YEAR_BASE     = 12'd1900;
	localparam logic [17:0] DAY_BIAS      = 18'd239;
	localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
	localparam logic signed [16:0] SEC_PER_QTR = 17'sd900;
	localparam logic signed [7:0] TZ_MIN  = -8'sd48;
	localparam logic signed [7:0] TZ_MAX  = 8'sd52;

	// floor(x / D) = (x * R) >> S over the operand ranges used here
	localparam logic [9:0]  RECIP12  = 10'd342;
	localparam int          SH12     = 12;
	localparam logic [11:0] RECIP100 = 12'd2622;
	localparam int          SH100    = 18;
	localparam logic [16:0] RECIP9   = 17'd116509;
	localparam int          SH9      = 20;

	typedef struct packed {
		logic               command;
		logic [7:0]         bin_year;
		logic [7:0]         bin_month;
		logic [7:0]         bin_day;
		logic [7:0]         bin_hour;
		logic [7:0]         bin_minute;
		logic [7:0]         bin_second;
		logic [63:0]        ascii_ymd;
		logic [47:0]        ascii_hms;
		logic signed [7:0]  tz_quarters;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] epoch_seconds;
		logic               valid_res;
	} out_item_t;

	typedef struct packed {
		logic [7:0]        yb;
		logic [7:0]        mb;
		logic [7:0]        db;
		logic [7:0]        hb;
		logic [7:0]        nb;
		logic [7:0]        sb;
		logic signed [7:0] tz;
	} date_t;

	typedef struct packed {
		logic               date_ok;
		logic signed [17:0] days;
		logic [19:0]        hms;
		logic signed [16:0] tzs;
	} days_t;

endpackage

FILE: rtl/idte_stream_if.sv
`timescale 1ns / 1ps

interface idte_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/idte_decode.sv
`timescale 1ns / 1ps

module idte_decode import idte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  in_item_t item,
	output logic     v_s1,
	output date_t    date_s1
);

	function automatic logic [7:0] dig(input logic [7:0] ch);
		return ch - ASCII_ZERO;
	endfunction

	function automatic logic [7:0] pair(input logic [15:0] chars);
		return dig(chars[15:8]) * 8'd10 + dig(chars[7:0]);
	endfunction

	date_t dec;
	logic [7:0] year_a;

	always_comb begin
		year_a = dig(item.ascii_ymd[63:56]) * 8'd232 + dig(item.ascii_ymd[55:48]) * 8'd100
			+ dig(item.ascii_ymd[47:40]) * 8'd10 + dig(item.ascii_ymd[39:32]) - YEAR_BASE_MOD;
		dec.tz = item.tz_quarters;
		case (item.command)
			CMD_ASCII: begin
				dec.yb = year_a;
				dec.mb = pair(item.ascii_ymd[31:16]);
				dec.db = pair(item.ascii_ymd[15:0]);
				dec.hb = pair(item.ascii_hms[47:32]);
				dec.nb = pair(item.ascii_hms[31:16]);
				dec.sb = pair(item.ascii_hms[15:0]);
			end
			default: begin
				dec.yb = item.bin_year;
				dec.mb = item.bin_month;
				dec.db = item.bin_day;
				dec.hb = item.bin_hour;
				dec.nb = item.bin_minute;
				dec.sb = item.bin_second;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			date_s1 <= dec;
		end
	end

endmodule

FILE: rtl/idte_days.sv
`timescale 1ns / 1ps

module idte_days import idte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  v_s1,
	input  date_t date_s1,
	output logic  v_s4,
	output days_t days_s4
);

	// stage 2
	logic               v_s2;
	logic [4:0]         q_s2;
	logic [16:0]        m275_s2;
	logic [11:0]        y_s2;
	logic [7:0]         yr_s2;
	logic [7:0]         d_s2;
	logic [19:0]        hms_s2;
	logic signed [16:0] tzs_s2;
	logic               ok_s2;

	// stage 3
	logic               v_s3;
	logic [11:0]        t1_s3;
	logic [4:0]         c_s3;
	logic [12:0]        m9_s3;
	logic [16:0]        y367_s3;
	logic [7:0]         d_s3;
	logic [19:0]        hms_s3;
	logic signed [16:0] tzs_s3;
	logic               ok_s3;

	logic [8:0]         mp9;
	logic [18:0]        q_prod;
	logic signed [16:0] tz_ext;
	logic [11:0]        yq;
	logic [11:0]        yq1;
	logic [13:0]        yq7;
	logic [23:0]        c_prod;
	logic [33:0]        m9_prod;
	logic [6:0]         c3;
	days_t              nxt4;

	always_comb begin
		mp9    = {1'b0, date_s1.mb} + 9'd9;
		q_prod = 19'(mp9) * 19'(RECIP12);
		tz_ext = 17'(date_s1.tz);
	end

	always_comb begin
		yq      = y_s2 + 12'(q_s2);
		yq1     = yq - 12'd1;
		yq7     = 14'(yq) * 14'd7;
		c_prod  = 24'(yq1) * 24'(RECIP100);
		m9_prod = 34'(m275_s2) * 34'(RECIP9);
	end

	always_comb begin
		c3           = (7'(c_s3) + 7'd1) * 7'd3;
		nxt4.date_ok = ok_s3;
		nxt4.days    = signed'(18'(y367_s3) - 18'(t1_s3) - 18'(c3[6:2]) + 18'(m9_s3)
			+ 18'(d_s3) - DAY_BIAS);
		nxt4.hms     = hms_s3;
		nxt4.tzs     = tzs_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s2    <= q_prod[SH12 +: 5];
			m275_s2 <= 17'(date_s1.mb) * 17'd275;
			y_s2    <= 12'(date_s1.yb) + YEAR_BASE;
			yr_s2   <= date_s1.yb - YEAR_OFF;
			d_s2    <= date_s1.db;
			hms_s2  <= 20'(date_s1.hb) * 20'd3600 + 20'(date_s1.nb) * 20'd60
				+ 20'(date_s1.sb);
			tzs_s2  <= (date_s1.tz >= TZ_MIN && date_s1.tz <= TZ_MAX) ?
				17'(tz_ext * SEC_PER_QTR) : 17'sd0;
			ok_s2   <= date_s1.yb >= MIN_YEAR;

			t1_s3   <= yq7[13:2];
			c_s3    <= c_prod[SH100 +: 5];
			m9_s3   <= m9_prod[SH9 +: 13];
			y367_s3 <= 17'(yr_s2) * 17'd367;
			d_s3    <= d_s2;
			hms_s3  <= hms_s2;
			tzs_s3  <= tzs_s2;
			ok_s3   <= ok_s2;

			days_s4 <= nxt4;
		end
	end

endmodule

FILE: rtl/idte_secs.sv
`timescale 1ns / 1ps

module idte_secs import idte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      v_s4,
	input  days_t     days_s4,
	output logic      v_s5,
	output out_item_t res_s5
);

	logic [31:0] secs;

	always_comb begin
		secs = 32'(days_s4.days) * 32'(SEC_PER_DAY) + 32'(days_s4.hms) - 32'(days_s4.tzs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5.epoch_seconds <= days_s4.date_ok ? signed'(secs) : 32'sd0;
			res_s5.valid_res     <= days_s4.date_ok;
		end
	end

endmodule

FILE: rtl/iso_date_to_epoch_seconds.sv
`timescale 1ns / 1ps

// Converts one ISO 9660 date (binary seven-byte or ASCII seventeen-byte form) to
// signed 32-bit seconds since 1970. Fully pipelined: one transaction is accepted
// every cycle and its result passes through decode, three calendar stages and the
// seconds multiply-add into the output register. The whole pipe stalls
// only while a finished result waits at the output; input ready is then low.
// Years before 1970 give 0 with valid_res low.

module iso_date_to_epoch_seconds import idte_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	idte_stream_if.sink   din,
	idte_stream_if.source dout
);

	logic      adv;
	logic      v_s1;
	logic      v_s4;
	logic      v_s5;
	date_t     date_s1;
	days_t     days_s4;
	out_item_t res_s5;

	assign adv        = !v_s5 || dout.ready;
	assign din.ready  = adv;
	assign dout.valid = v_s5;
	assign dout.data  = res_s5;

	idte_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (din.valid),
		.item     (din.data),
		.v_s1     (v_s1),
		.date_s1  (date_s1)
	);

	idte_days u_days (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s1    (v_s1),
		.date_s1 (date_s1),
		.v_s4    (v_s4),
		.days_s4 (days_s4)
	);

	idte_secs u_secs (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s4    (v_s4),
		.days_s4 (days_s4),
		.v_s5    (v_s5),
		.res_s5  (res_s5)
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.data.valid_res |-> dout.data.epoch_seconds == 32'sd0)
		else $error("invalid date with nonzero seconds");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> dout.valid && !dout.ready)
		else $error("input stalled without a waiting result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready ##1 din.ready ##1 din.ready ##1 din.ready ##1 din.ready
		|=> dout.valid)
		else $error("transaction lost in pipeline");

endmodule
